// ----- sv/stbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table bound search - shared definitions
// Function codes, status codes and the result record shared by the search sequencer and the top level.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int POS_W = 12;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_MIN    = 2'd2;
  localparam logic [1:0] FN_MAX    = 2'd3;

  localparam logic [1:0] ST_EXACT = 2'd0;
  localparam logic [1:0] ST_NEAR  = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [1:0]       status;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/stbs_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table value store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stbs_store #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [AW-1:0]               waddr,
  input  wire  signed [VALUE_BITS-1:0] wdata,
  input  wire  [AW-1:0]               raddr,
  output logic signed [VALUE_BITS-1:0] rdata
);

  logic signed [VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/stbs_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bound search sequencer
// Handles clear and append, and runs the binary search against the store,
// one probe per cycle, followed by an exact-match check on the found entry when it lies in the table.
// ----------------------------------------------------------------------------
module stbs_search
  import stbs_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   in_func,
  input  wire  signed [VALUE_BITS-1:0] in_value,
  output logic                         res_valid,
  input  wire                          res_ready,
  output res_t                         res,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic signed [VALUE_BITS-1:0] mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  wire  signed [VALUE_BITS-1:0] mem_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_VERIFY = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         is_max_r, is_max_nxt;
  logic                         desc_r, desc_nxt;
  logic signed [VALUE_BITS-1:0] tgt_r, tgt_nxt;
  logic signed [VALUE_BITS-1:0] first_r, first_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                mid_r, mid_nxt;
  logic signed [CW:0]           pos_r, pos_nxt;
  res_t                         res_r, res_nxt;

  logic                         pred;
  logic                         minus;
  logic [CW-1:0]                lo_step, hi_step, mid_calc;
  logic signed [CW:0]           pos_calc;
  logic                         in_range;
  logic                         asc;
  logic                         below, above;
  logic signed [CW:0]           n_s, nm1_s;
  logic [CW-1:0]                cnt_inc, cnt_dec;

  // Sign-extend or truncate an index to the result width.
  function automatic logic [POS_W-1:0] to_pos(input logic signed [CW:0] p);
    logic signed [CW+POS_W:0] w;
    w = p;
    return w[POS_W-1:0];
  endfunction

  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign n_s     = signed'({1'b0, cnt_r});
  assign nm1_s   = n_s - 2'sb01;

  // Ascending min looks for >=, ascending max for >; descending inverts both.
  assign pred = (is_max_r ? (mem_rdata > tgt_r) : (mem_rdata >= tgt_r)) ^ desc_r;
  // Ascending max and descending min report one below the first hit.
  assign minus    = is_max_r ^ desc_r;
  assign lo_step  = pred ? lo_r : mid_r + 1'b1;
  assign hi_step  = pred ? mid_r : hi_r;
  assign mid_calc = lo_step + ((hi_step - lo_step) >> 1);
  assign pos_calc = signed'({1'b0, lo_step}) - (minus ? 2'sb01 : 2'sb00);
  assign in_range = minus ? (lo_step != '0) : (lo_step != cnt_r);

  // In the check state the read data is the last entry.
  assign asc   = mem_rdata >= first_r;
  assign below = tgt_r < (asc ? first_r : mem_rdata);
  assign above = tgt_r > (asc ? mem_rdata : first_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_max_nxt = is_max_r;
    desc_nxt   = desc_r;
    tgt_nxt    = tgt_r;
    first_nxt  = first_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    pos_nxt    = pos_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = cnt_r[AW-1:0];
    mem_wdata  = in_value;
    mem_raddr  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt    = in_value;
          is_max_nxt = (in_func == FN_MAX);
          unique case (in_func)
            FN_CLEAR: begin
              cnt_nxt   = '0;
              res_nxt   = '{position: '0, status: ST_EXACT};
              state_nxt = S_DONE;
            end
            FN_APPEND: begin
              if (cnt_r != DEPTH_C) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_inc;
                res_nxt = '{position: to_pos(signed'({1'b0, cnt_inc})), status: ST_EXACT};
              end else begin
                res_nxt = '{position: to_pos(n_s), status: ST_BAD};
              end
              state_nxt = S_DONE;
            end
            FN_MIN, FN_MAX: begin
              if (cnt_r == '0) begin
                res_nxt   = '{position: '0, status: ST_BAD};
                state_nxt = S_DONE;
              end else begin
                mem_raddr = '0;
                state_nxt = S_FIRST;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIRST: begin
        first_nxt = mem_rdata;
        mem_raddr = cnt_dec[AW-1:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        desc_nxt = !asc;
        if (below || above) begin
          state_nxt       = S_DONE;
          res_nxt.status  = ST_OUT;
          if (asc && !is_max_r) begin
            res_nxt.position = above ? to_pos(n_s) : '0;
          end else if (asc) begin
            res_nxt.position = below ? '1 : to_pos(nm1_s);
          end else if (!is_max_r) begin
            res_nxt.position = below ? to_pos(nm1_s) : '1;
          end else begin
            res_nxt.position = above ? '0 : to_pos(n_s);
          end
        end else begin
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          mid_nxt   = cnt_r >> 1;
          mem_raddr = mid_nxt[AW-1:0];
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt   = mid_calc;
          mem_raddr = mid_calc[AW-1:0];
        end else begin
          pos_nxt = pos_calc;
          if (in_range) begin
            mem_raddr = pos_calc[AW-1:0];
            state_nxt = S_VERIFY;
          end else begin
            res_nxt   = '{position: to_pos(pos_calc), status: ST_NEAR};
            state_nxt = S_DONE;
          end
        end
      end
      S_VERIFY: begin
        res_nxt   = '{position: to_pos(pos_r),
                      status: (mem_rdata == tgt_r) ? ST_EXACT : ST_NEAR};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_max_r <= is_max_nxt;
    desc_r   <= desc_nxt;
    tgt_r    <= tgt_nxt;
    first_r  <= first_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    res_r    <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> (lo_r <= mid_r) && (mid_r < hi_r) && (hi_r <= cnt_r))
    else $error("probe outside search window");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_APPEND) && (cnt_r != DEPTH_C)
    |=> cnt_r == $past(cnt_inc))
    else $error("append did not advance count");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !res_ready |=> state_r == S_DONE && $stable(res_r))
    else $error("pending result lost");
`endif

endmodule
`default_nettype wire

// ----- sv/sorted_table_bound_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Clear, append and a query on an empty table go straight to the done state;
// other queries read the first and last entries and end there when the target
// lies outside the table. A search then probes the store, one probe per cycle,
// and checks the found entry for an exact match unless the bound falls off the
// table. One item is in work at a time; the next beat is taken the cycle after the
// result moves into the output register. Synchronous active-low reset empties the table.
// ----------------------------------------------------------------------------
// Sorted table bound search
// Loads a monotonic table and answers min and max bound queries on it.
// ----------------------------------------------------------------------------
module sorted_table_bound_search
  import stbs_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  input  wire  [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [11:0] position, [15:12] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = $clog2(DEPTH);

  logic signed [VALUE_BITS+31:0] value_ext;
  logic signed [VALUE_BITS-1:0]  value;
  logic                          res_valid;
  logic                          res_ready;
  res_t                          res;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic signed [VALUE_BITS-1:0]  mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic signed [VALUE_BITS-1:0]  mem_rdata;
  logic                          out_valid_r, out_valid_nxt;
  res_t                          out_res_r, out_res_nxt;

  // The 32-bit input is sign-extended or cut down to the table width.
  assign value_ext = signed'(in_tdata);
  assign value     = value_ext[VALUE_BITS-1:0];

  stbs_search #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_value  (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  stbs_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.position};
  assign out_tuser  = out_res_r.status;

endmodule
`default_nettype wire
